// ===== design/vsht_pkg.sv =====
// ----------------------------------------------------------------------------
// vsht_pkg: shared types and constants of the voice slot handle table
// Field widths, table depth, mode codes, controller states and the command
// bundle between controller and datapath.
// ----------------------------------------------------------------------------
package vsht_pkg;

  localparam int MAX_VOICES = 128;
  localparam int SLOT_W     = 7;
  localparam int TAG_W      = 32;
  localparam int WORD_W     = 32;
  localparam int HANDLE_W   = 64;
  localparam int COUNT_W    = 8;
  localparam int MODE_W     = 3;

  // Free-slot search: groups of GROUP_W slots, then a pick among groups
  localparam int GROUP_W     = 8;
  localparam int GROUP_IDX_W = 3;
  localparam int N_GROUPS    = (MAX_VOICES + GROUP_W - 1) / GROUP_W;
  localparam int GROUP_SEL_W = SLOT_W - GROUP_IDX_W;

  localparam logic [COUNT_W-1:0] COUNT_RESET = 8'd32;

  typedef enum logic [MODE_W-1:0] {
    MODE_PLAY       = 3'd0,
    MODE_STOP_VOICE = 3'd1,
    MODE_QUERY      = 3'd2,
    MODE_SET_VOLUME = 3'd3,
    MODE_SET_PITCH  = 3'd4,
    MODE_MIX        = 3'd5,
    MODE_START      = 3'd6,
    MODE_STOP_ALL   = 3'd7
  } mode_e;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_EXEC = 1'b1
  } state_e;

  // Commands from controller to datapath
  typedef struct packed {
    logic capture;  // latch the item, read the slot memories
    logic commit;   // update the table and load the output register
  } vsht_cmd_t;

endpackage

// ===== design/vsht_free_find.sv =====
// ----------------------------------------------------------------------------
// vsht_free_find: lowest free slot search
// First level finds the lowest free slot in each group and registers it;
// second level picks the lowest group that has one.
// ----------------------------------------------------------------------------
module vsht_free_find (
  input  logic                              clk_i,
  input  logic                              capture_i,
  input  logic [vsht_pkg::MAX_VOICES-1:0]   free_i,
  output logic                              found_o,
  output logic [vsht_pkg::SLOT_W-1:0]       idx_o
);

  logic [vsht_pkg::N_GROUPS*vsht_pkg::GROUP_W-1:0] free_pad;
  logic [vsht_pkg::N_GROUPS-1:0]                   any_d, any_q;
  logic [vsht_pkg::GROUP_IDX_W-1:0]                sub_d [vsht_pkg::N_GROUPS];
  logic [vsht_pkg::GROUP_IDX_W-1:0]                sub_q [vsht_pkg::N_GROUPS];

  // Pad the free vector to whole groups
  always_comb begin
    free_pad = '0;
    free_pad[vsht_pkg::MAX_VOICES-1:0] = free_i;
  end

  // Lowest free slot inside each group
  always_comb begin
    for (int g = 0; g < vsht_pkg::N_GROUPS; g++) begin
      any_d[g] = 1'b0;
      sub_d[g] = '0;
      for (int b = vsht_pkg::GROUP_W - 1; b >= 0; b--) begin
        if (free_pad[g*vsht_pkg::GROUP_W + b]) begin
          any_d[g] = 1'b1;
          sub_d[g] = vsht_pkg::GROUP_IDX_W'(b);
        end
      end
    end
  end

  // Hold group results for the execute cycle
  always_ff @(posedge clk_i) begin
    if (capture_i) begin
      any_q <= any_d;
      for (int g = 0; g < vsht_pkg::N_GROUPS; g++) begin
        sub_q[g] <= sub_d[g];
      end
    end
  end

  // Lowest group with a free slot
  always_comb begin
    found_o = 1'b0;
    idx_o   = '0;
    for (int g = vsht_pkg::N_GROUPS - 1; g >= 0; g--) begin
      if (any_q[g]) begin
        found_o = 1'b1;
        idx_o   = {vsht_pkg::GROUP_SEL_W'(g), sub_q[g]};
      end
    end
  end

endmodule

// ===== design/vsht_ctrl.sv =====
// ----------------------------------------------------------------------------
// vsht_ctrl: item sequencer
// Takes one item, executes it and hands the result to the output
// register, waiting in the execute state while the output is full and stalled.
// ----------------------------------------------------------------------------
module vsht_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output vsht_pkg::vsht_cmd_t cmd_o
);

  vsht_pkg::state_e state_q, state_d;
  logic             out_valid_q, out_valid_d;

  // State and output valid registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= vsht_pkg::ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Next state and commands
  always_comb begin
    state_d       = state_q;
    cmd_o.capture = 1'b0;
    cmd_o.commit  = 1'b0;
    in_stall_o    = 1'b1;
    unique case (state_q)
      vsht_pkg::ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = vsht_pkg::ST_EXEC;
        end
      end
      vsht_pkg::ST_EXEC: begin
        if (!out_valid_q || !out_stall_i) begin
          cmd_o.commit = 1'b1;
          state_d      = vsht_pkg::ST_IDLE;
        end
      end
      default: state_d = vsht_pkg::ST_IDLE;
    endcase
    // Drop the result once taken, refill on commit
    if (cmd_o.commit) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  assign out_valid_o = out_valid_q;

`ifndef NO_ASSERTIONS
  a_commit_in_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.commit |-> state_q == vsht_pkg::ST_EXEC)
    else $error("commit outside execute state");
  a_valid_from_commit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(cmd_o.commit))
    else $error("output valid rose without a commit");
`endif

endmodule

// ===== design/vsht_datapath.sv =====
// ----------------------------------------------------------------------------
// vsht_datapath: slot flags, slot memories and result register
// Holds per-slot flags in flops and per-slot words in memories, evaluates
// an item in the execute cycle and loads the output register on commit.
// ----------------------------------------------------------------------------
module vsht_datapath (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  vsht_pkg::vsht_cmd_t              cmd_i,
  input  logic                             cfg_we_i,
  input  logic [vsht_pkg::COUNT_W-1:0]     cfg_data_i,
  input  logic [vsht_pkg::MODE_W-1:0]      mode_i,
  input  logic [vsht_pkg::HANDLE_W-1:0]    handle_i,
  input  logic [vsht_pkg::SLOT_W-1:0]      voice_slot_i,
  input  logic                             stream_ended_i,
  input  logic [vsht_pkg::WORD_W-1:0]      offset_word_i,
  input  logic [vsht_pkg::WORD_W-1:0]      volume_word_i,
  input  logic [vsht_pkg::WORD_W-1:0]      pitch_word_i,
  output logic                             ok_o,
  output logic [vsht_pkg::HANDLE_W-1:0]    handle_out_o,
  output logic                             start_now_o,
  output logic                             fade_out_o,
  output logic                             voice_freed_o,
  output logic [vsht_pkg::WORD_W-1:0]      ramp_from_o,
  output logic [vsht_pkg::WORD_W-1:0]      ramp_to_o,
  output logic [vsht_pkg::WORD_W-1:0]      pitch_out_o,
  output logic [vsht_pkg::WORD_W-1:0]      offset_out_o
);

  localparam int MV = vsht_pkg::MAX_VOICES;
  localparam int SW = vsht_pkg::SLOT_W;
  localparam int WW = vsht_pkg::WORD_W;
  localparam int TW = vsht_pkg::TAG_W;

  // Configuration and control state
  logic [vsht_pkg::COUNT_W-1:0] voice_count_q, eff_count;
  logic [MV-1:0] active_q, active_d, stop_q, stop_d, pend_q, pend_d;
  logic [TW-1:0] next_tag_q, next_tag_d;
  logic          running_q, running_d;

  // Latched item
  vsht_pkg::mode_e mode_q;
  logic [SW-1:0]   slot_q;
  logic            hi_zero_q;
  logic [TW-1:0]   tag_in_q;
  logic            ended_q;
  logic [WW-1:0]   off_q, vol_q, pit_q;

  // Slot memories and their read registers
  logic [TW-1:0] tag_mem   [MV];
  logic [WW-1:0] vol_mem   [MV];
  logic [WW-1:0] prev_mem  [MV];
  logic [WW-1:0] pitch_mem [MV];
  logic [WW-1:0] off_mem   [MV];
  logic [TW-1:0] tag_rd_q;
  logic [WW-1:0] vol_rd_q, prev_rd_q, pitch_rd_q, off_rd_q;

  logic [SW-1:0] raddr, waddr;
  logic          hi_zero_d;
  logic          we_all, we_vol, we_pitch, we_prev;
  logic [WW-1:0] vol_wdata, prev_wdata;

  logic [MV-1:0] free_vec;
  logic          found;
  logic [SW-1:0] free_idx;

  logic in_range, active_sel, handle_ok, mix_ok;

  // Result before the output register
  logic                          res_ok, res_start, res_fade, res_freed;
  logic [vsht_pkg::HANDLE_W-1:0] res_handle;
  logic [WW-1:0]                 res_from, res_to, res_pitch, res_off;

  // Voice count register; its effective value is saturated to the table depth
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      voice_count_q <= vsht_pkg::COUNT_RESET;
    end else if (cfg_we_i) begin
      voice_count_q <= cfg_data_i;
    end
  end

  assign eff_count = (voice_count_q > vsht_pkg::COUNT_W'(MV)) ?
                     vsht_pkg::COUNT_W'(MV) : voice_count_q;

  // Free slots among those in use
  always_comb begin
    for (int i = 0; i < MV; i++) begin
      free_vec[i] = !active_q[i] && (vsht_pkg::COUNT_W'(i) < eff_count);
    end
  end

  vsht_free_find u_free_find (
    .clk_i     (clk_i),
    .capture_i (cmd_i.capture),
    .free_i    (free_vec),
    .found_o   (found),
    .idx_o     (free_idx)
  );

  // Read address: mix slot or handle slot
  assign raddr     = (vsht_pkg::mode_e'(mode_i) == vsht_pkg::MODE_MIX) ?
                     voice_slot_i : handle_i[TW+SW-1:TW];
  assign hi_zero_d = (vsht_pkg::mode_e'(mode_i) == vsht_pkg::MODE_MIX) ||
                     (handle_i[vsht_pkg::HANDLE_W-1:TW+SW] == '0);

  // Latch the item
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      mode_q    <= vsht_pkg::mode_e'(mode_i);
      slot_q    <= raddr;
      hi_zero_q <= hi_zero_d;
      tag_in_q  <= handle_i[TW-1:0];
      ended_q   <= stream_ended_i;
      off_q     <= offset_word_i;
      vol_q     <= volume_word_i;
      pit_q     <= pitch_word_i;
    end
  end

  // Slot memories: read on capture, write on commit
  always_ff @(posedge clk_i) begin
    if (we_all) begin
      tag_mem[waddr] <= next_tag_q;
      off_mem[waddr] <= off_q;
    end
    if (we_vol) begin
      vol_mem[waddr] <= vol_wdata;
    end
    if (we_prev) begin
      prev_mem[waddr] <= prev_wdata;
    end
    if (we_pitch) begin
      pitch_mem[waddr] <= pit_q;
    end
    if (cmd_i.capture) begin
      tag_rd_q   <= tag_mem[raddr];
      vol_rd_q   <= vol_mem[raddr];
      prev_rd_q  <= prev_mem[raddr];
      pitch_rd_q <= pitch_mem[raddr];
      off_rd_q   <= off_mem[raddr];
    end
  end

  // Lookup of the latched slot
  assign in_range   = hi_zero_q && (vsht_pkg::COUNT_W'(slot_q) < eff_count);
  assign active_sel = active_q[slot_q];
  assign handle_ok  = in_range && active_sel && (tag_rd_q == tag_in_q);
  assign mix_ok     = running_q && in_range && active_sel;

  // Execute the item
  always_comb begin
    active_d   = active_q;
    stop_d     = stop_q;
    pend_d     = pend_q;
    next_tag_d = next_tag_q;
    running_d  = running_q;
    waddr      = slot_q;
    we_all     = 1'b0;
    we_vol     = 1'b0;
    we_prev    = 1'b0;
    we_pitch   = 1'b0;
    vol_wdata  = vol_q;
    prev_wdata = vol_q;
    res_ok     = 1'b0;
    res_handle = '0;
    res_start  = 1'b0;
    res_fade   = 1'b0;
    res_freed  = 1'b0;
    res_from   = '0;
    res_to     = '0;
    res_pitch  = '0;
    res_off    = '0;
    unique case (mode_q)
      vsht_pkg::MODE_PLAY: begin
        if (found) begin
          waddr            = free_idx;
          we_all           = 1'b1;
          we_vol           = 1'b1;
          we_prev          = 1'b1;
          we_pitch         = 1'b1;
          next_tag_d       = next_tag_q + TW'(1);
          stop_d[free_idx] = 1'b0;
          pend_d[free_idx] = 1'b1;
          active_d[free_idx] = 1'b1;
          res_ok           = 1'b1;
          res_handle       = {(vsht_pkg::HANDLE_W - TW)'(free_idx), next_tag_q};
        end
      end
      vsht_pkg::MODE_STOP_VOICE: begin
        res_ok = handle_ok;
        if (handle_ok) begin
          stop_d[slot_q] = 1'b1;
        end
      end
      vsht_pkg::MODE_QUERY: begin
        res_ok = handle_ok;
      end
      vsht_pkg::MODE_SET_VOLUME: begin
        res_ok = handle_ok;
        we_vol = handle_ok;
      end
      vsht_pkg::MODE_SET_PITCH: begin
        res_ok   = handle_ok;
        we_pitch = handle_ok;
      end
      vsht_pkg::MODE_MIX: begin
        if (mix_ok) begin
          res_ok     = 1'b1;
          res_from   = prev_rd_q;
          res_to     = vol_rd_q;
          res_pitch  = pitch_rd_q;
          res_off    = off_rd_q;
          we_prev    = 1'b1;
          prev_wdata = vol_rd_q;
          // Stopped before it ever played: free without start or fade
          if (stop_q[slot_q] && pend_q[slot_q]) begin
            active_d[slot_q] = 1'b0;
            res_freed        = 1'b1;
          end else begin
            res_fade       = stop_q[slot_q];
            res_start      = pend_q[slot_q];
            pend_d[slot_q] = 1'b0;
            if (ended_q || stop_q[slot_q]) begin
              active_d[slot_q] = 1'b0;
              res_freed        = 1'b1;
            end
          end
        end
      end
      vsht_pkg::MODE_START: begin
        if (running_q) begin
          active_d = '0;
          stop_d   = '0;
        end
        running_d = 1'b1;
      end
      vsht_pkg::MODE_STOP_ALL: begin
        if (running_q) begin
          active_d  = '0;
          stop_d    = '0;
          running_d = 1'b0;
        end
      end
      default: begin
        res_ok = 1'b0;
      end
    endcase
    // Gate all writes by commit
    if (!cmd_i.commit) begin
      active_d   = active_q;
      stop_d     = stop_q;
      pend_d     = pend_q;
      next_tag_d = next_tag_q;
      running_d  = running_q;
      we_all     = 1'b0;
      we_vol     = 1'b0;
      we_prev    = 1'b0;
      we_pitch   = 1'b0;
    end
  end

  // Flag and counter registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q   <= '0;
      stop_q     <= '0;
      pend_q     <= '0;
      next_tag_q <= '0;
      running_q  <= 1'b0;
    end else begin
      active_q   <= active_d;
      stop_q     <= stop_d;
      pend_q     <= pend_d;
      next_tag_q <= next_tag_d;
      running_q  <= running_d;
    end
  end

  // Output register
  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      ok_o          <= res_ok;
      handle_out_o  <= res_handle;
      start_now_o   <= res_start;
      fade_out_o    <= res_fade;
      voice_freed_o <= res_freed;
      ramp_from_o   <= res_from;
      ramp_to_o     <= res_to;
      pitch_out_o   <= res_pitch;
      offset_out_o  <= res_off;
    end
  end

`ifndef NO_ASSERTIONS
  a_play_takes_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.commit && mode_q == vsht_pkg::MODE_PLAY && found) |-> !active_q[free_idx])
    else $error("play picked an active slot");
  a_play_marks_active: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.commit && mode_q == vsht_pkg::MODE_PLAY && found) |=>
      active_q[$past(free_idx)])
    else $error("played slot not active");
  a_tag_only_on_play: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(cmd_i.commit && mode_q == vsht_pkg::MODE_PLAY && found) |=> $stable(next_tag_q))
    else $error("tag counter moved without a successful play");
`endif

endmodule

// ===== design/voice_slot_handle_table.sv =====
// ----------------------------------------------------------------------------
// voice_slot_handle_table: voice slot table with generational handles
// Allocates voice slots, validates handles and reports per-slot mix events.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_stall_o) carries one command item: play,
//   stop voice, query, set volume, set pitch, mix voice, start or stop all.
//   Output channel (out_valid_o / out_stall_i) returns exactly one result
//   item per command item, in order.
//   Configuration channel (cfg_valid_i / cfg_ready_o) writes voice_count;
//   it is always ready and should be written only while the block is idle.
//   Each item passes a capture step (slot memory read and first search
//   level) and then an execute step (tag compare, lowest-group pick and
//   table update); no new item is accepted during the execute step.
//   The output register lets the next item be accepted while a result
//   waits; while the receiver stalls a full output, the execute cycle of
//   the following item holds and the input stalls.
//   Reset clears all slot flags, the tag counter and the running flag and
//   sets voice_count to 32; slot words stay undefined until a play writes
//   them, and no clearing pass is needed.
// ----------------------------------------------------------------------------
module voice_slot_handle_table (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [vsht_pkg::COUNT_W-1:0]     cfg_data_i,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic [vsht_pkg::MODE_W-1:0]      mode_i,
  input  logic [vsht_pkg::HANDLE_W-1:0]    handle_i,
  input  logic [vsht_pkg::SLOT_W-1:0]      voice_slot_i,
  input  logic                             stream_ended_i,
  input  logic [vsht_pkg::WORD_W-1:0]      offset_word_i,
  input  logic [vsht_pkg::WORD_W-1:0]      volume_word_i,
  input  logic [vsht_pkg::WORD_W-1:0]      pitch_word_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic                             ok_o,
  output logic [vsht_pkg::HANDLE_W-1:0]    handle_out_o,
  output logic                             start_now_o,
  output logic                             fade_out_o,
  output logic                             voice_freed_o,
  output logic [vsht_pkg::WORD_W-1:0]      ramp_from_o,
  output logic [vsht_pkg::WORD_W-1:0]      ramp_to_o,
  output logic [vsht_pkg::WORD_W-1:0]      pitch_out_o,
  output logic [vsht_pkg::WORD_W-1:0]      offset_out_o
);

  vsht_pkg::vsht_cmd_t cmd;
  logic                cfg_we;

  // Accept configuration writes at any time
  assign cfg_ready_o = 1'b1;
  assign cfg_we      = cfg_valid_i && cfg_ready_o;

  vsht_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cmd_o       (cmd)
  );

  vsht_datapath u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .cfg_we_i       (cfg_we),
    .cfg_data_i     (cfg_data_i),
    .mode_i         (mode_i),
    .handle_i       (handle_i),
    .voice_slot_i   (voice_slot_i),
    .stream_ended_i (stream_ended_i),
    .offset_word_i  (offset_word_i),
    .volume_word_i  (volume_word_i),
    .pitch_word_i   (pitch_word_i),
    .ok_o           (ok_o),
    .handle_out_o   (handle_out_o),
    .start_now_o    (start_now_o),
    .fade_out_o     (fade_out_o),
    .voice_freed_o  (voice_freed_o),
    .ramp_from_o    (ramp_from_o),
    .ramp_to_o      (ramp_to_o),
    .pitch_out_o    (pitch_out_o),
    .offset_out_o   (offset_out_o)
  );

endmodule

// ===== sim/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking testbench for voice_slot_handle_table
// A mirror of the voice table works out one expected result per accepted
// item and compares every returned result field by field, in order. A short
// directed part walks the voice life cycle; random phases follow under
// several voice counts and idling patterns.
// ----------------------------------------------------------------------------
import vsht_pkg::*;

typedef struct packed {
  mode_e               mode;
  logic [HANDLE_W-1:0] handle;
  logic [SLOT_W-1:0]   voice_slot;
  logic                stream_ended;
  logic [WORD_W-1:0]   offset_word;
  logic [WORD_W-1:0]   volume_word;
  logic [WORD_W-1:0]   pitch_word;
} voice_cmd_t;

typedef struct packed {
  logic                ok;
  logic [HANDLE_W-1:0] handle_out;
  logic                start_now;
  logic                fade_out;
  logic                voice_freed;
  logic [WORD_W-1:0]   ramp_from;
  logic [WORD_W-1:0]   ramp_to;
  logic [WORD_W-1:0]   pitch_out;
  logic [WORD_W-1:0]   offset_out;
} voice_result_t;

// Mirror of the voice table and the queue of results it still owes
class voice_table_mirror;
  logic [COUNT_W-1:0] count_reg;
  bit                 voice_on[MAX_VOICES];
  bit                 stop_flag[MAX_VOICES];
  bit                 start_flag[MAX_VOICES];
  bit                 ever_played[MAX_VOICES];
  logic [TAG_W-1:0]   voice_tag[MAX_VOICES];
  logic [WORD_W-1:0]  cur_vol[MAX_VOICES];
  logic [WORD_W-1:0]  old_vol[MAX_VOICES];
  logic [WORD_W-1:0]  pitch_w[MAX_VOICES];
  logic [WORD_W-1:0]  offset_w[MAX_VOICES];
  logic [TAG_W-1:0]   tag_counter;
  bit                 playing;
  voice_result_t      owed_results[$];
  int errors, n_items, n_results, n_alloc, n_full, n_handle_ok, n_mix_hit, n_freed;

  function new();
    count_reg   = COUNT_RESET;
    tag_counter = '0;
    playing     = 1'b0;
    for (int i = 0; i < MAX_VOICES; i++) begin
      voice_on[i]    = 1'b0;
      stop_flag[i]   = 1'b0;
      start_flag[i]  = 1'b0;
      ever_played[i] = 1'b0;
      voice_tag[i]   = '0;
      cur_vol[i]     = '0;
      old_vol[i]     = '0;
      pitch_w[i]     = '0;
      offset_w[i]    = '0;
    end
  endfunction

  function int usable_slots();
    return (count_reg > MAX_VOICES) ? MAX_VOICES : int'(count_reg);
  endfunction

  function void set_count(logic [COUNT_W-1:0] v);
    count_reg = v;
  endfunction

  function logic [HANDLE_W-1:0] live_handle(int s);
    return {32'(s), voice_tag[s]};
  endfunction

  // Slot of a valid handle, or -1
  function int resolve_handle(logic [HANDLE_W-1:0] h);
    logic [31:0] idx;
    idx = h[63:32];
    if (idx >= usable_slots()) return -1;
    if (!voice_on[idx]) return -1;
    if (voice_tag[idx] != h[31:0]) return -1;
    return int'(idx);
  endfunction

  function void clear_voices();
    for (int i = 0; i < MAX_VOICES; i++) begin
      voice_on[i]  = 1'b0;
      stop_flag[i] = 1'b0;
    end
  endfunction

  // Advance the table by one accepted item and queue its result
  function void accept_cmd(voice_cmd_t c);
    voice_result_t r;
    int n, s, v;
    r = '0;
    n = usable_slots();
    s = -1;
    n_items++;
    case (c.mode)
      MODE_PLAY: begin
        for (int i = 0; i < n; i++)
          if (!voice_on[i] && s < 0) s = i;
        if (s < 0) begin
          n_full++;
        end else begin
          offset_w[s]    = c.offset_word;
          cur_vol[s]     = c.volume_word;
          old_vol[s]     = c.volume_word;
          pitch_w[s]     = c.pitch_word;
          voice_tag[s]   = tag_counter;
          tag_counter    = tag_counter + TAG_W'(1);
          stop_flag[s]   = 1'b0;
          start_flag[s]  = 1'b1;
          voice_on[s]    = 1'b1;
          ever_played[s] = 1'b1;
          r.ok           = 1'b1;
          r.handle_out   = live_handle(s);
          n_alloc++;
        end
      end
      MODE_STOP_VOICE, MODE_QUERY, MODE_SET_VOLUME, MODE_SET_PITCH: begin
        s = resolve_handle(c.handle);
        if (s >= 0) begin
          r.ok = 1'b1;
          n_handle_ok++;
          case (c.mode)
            MODE_STOP_VOICE: stop_flag[s] = 1'b1;
            MODE_SET_VOLUME: cur_vol[s] = c.volume_word;
            MODE_SET_PITCH:  pitch_w[s] = c.pitch_word;
            default: ;
          endcase
        end
      end
      MODE_MIX: begin
        v = int'(c.voice_slot);
        if (playing && v < n && voice_on[v]) begin
          r.ok         = 1'b1;
          r.ramp_from  = old_vol[v];
          r.ramp_to    = cur_vol[v];
          r.pitch_out  = pitch_w[v];
          r.offset_out = offset_w[v];
          old_vol[v]   = cur_vol[v];
          n_mix_hit++;
          if (stop_flag[v] && start_flag[v]) begin
            // stopped before it ever sounded: free silently
            voice_on[v]   = 1'b0;
            r.voice_freed = 1'b1;
          end else begin
            r.fade_out    = stop_flag[v];
            r.start_now   = start_flag[v];
            start_flag[v] = 1'b0;
            if (c.stream_ended || stop_flag[v]) begin
              voice_on[v]   = 1'b0;
              r.voice_freed = 1'b1;
            end
          end
          if (r.voice_freed) n_freed++;
        end
      end
      MODE_START: begin
        if (playing) clear_voices();
        playing = 1'b1;
      end
      default: begin
        if (playing) begin
          clear_voices();
          playing = 1'b0;
        end
      end
    endcase
    owed_results.push_back(r);
  endfunction

  function void check_field(string name, logic [63:0] exp_v, logic [63:0] act_v);
    if (act_v !== exp_v) begin
      $display("%0t: %s mismatch: expected %h, actual %h", $time, name, exp_v, act_v);
      errors++;
    end
  endfunction

  // Compare a returned result with the oldest one owed
  function void compare_result(voice_result_t act);
    voice_result_t exp_r;
    if (owed_results.size() == 0) begin
      $display("%0t: unexpected result: expected none, actual ok=%0b handle_out=%h",
               $time, act.ok, act.handle_out);
      errors++;
      return;
    end
    exp_r = owed_results.pop_front();
    n_results++;
    check_field("ok",          exp_r.ok,          act.ok);
    check_field("handle_out",  exp_r.handle_out,  act.handle_out);
    check_field("start_now",   exp_r.start_now,   act.start_now);
    check_field("fade_out",    exp_r.fade_out,    act.fade_out);
    check_field("voice_freed", exp_r.voice_freed, act.voice_freed);
    check_field("ramp_from",   exp_r.ramp_from,   act.ramp_from);
    check_field("ramp_to",     exp_r.ramp_to,     act.ramp_to);
    check_field("pitch_out",   exp_r.pitch_out,   act.pitch_out);
    check_field("offset_out",  exp_r.offset_out,  act.offset_out);
  endfunction

  function int results_owed();
    return owed_results.size();
  endfunction
endclass

module tb;

  localparam int CYCLE_LIMIT    = 400000;
  localparam int N_PHASES       = 8;
  localparam int ITEMS_PER_PHASE = 125;

  logic                clk          = 1'b0;
  logic                rst_n        = 1'b0;
  logic                cfg_valid    = 1'b0;
  logic                cfg_ready;
  logic [COUNT_W-1:0]  cfg_data     = '0;
  logic                in_valid     = 1'b0;
  logic                in_stall;
  mode_e               mode         = MODE_PLAY;
  logic [HANDLE_W-1:0] handle       = '0;
  logic [SLOT_W-1:0]   voice_slot   = '0;
  logic                stream_ended = 1'b0;
  logic [WORD_W-1:0]   offset_word  = '0;
  logic [WORD_W-1:0]   volume_word  = '0;
  logic [WORD_W-1:0]   pitch_word   = '0;
  logic                out_valid;
  logic                out_stall    = 1'b0;
  logic                ok;
  logic [HANDLE_W-1:0] handle_out;
  logic                start_now;
  logic                fade_out;
  logic                voice_freed;
  logic [WORD_W-1:0]   ramp_from;
  logic [WORD_W-1:0]   ramp_to;
  logic [WORD_W-1:0]   pitch_out;
  logic [WORD_W-1:0]   offset_out;

  voice_table_mirror   sb;
  int                  send_idle_pct  = 0;
  int                  recv_stall_pct = 0;
  int                  cycle_count    = 0;
  logic [COUNT_W-1:0]  count_plan [N_PHASES];
  voice_cmd_t          dcmd;

  voice_slot_handle_table i_dut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .cfg_valid_i    (cfg_valid),
    .cfg_ready_o    (cfg_ready),
    .cfg_data_i     (cfg_data),
    .in_valid_i     (in_valid),
    .in_stall_o     (in_stall),
    .mode_i         (mode),
    .handle_i       (handle),
    .voice_slot_i   (voice_slot),
    .stream_ended_i (stream_ended),
    .offset_word_i  (offset_word),
    .volume_word_i  (volume_word),
    .pitch_word_i   (pitch_word),
    .out_valid_o    (out_valid),
    .out_stall_i    (out_stall),
    .ok_o           (ok),
    .handle_out_o   (handle_out),
    .start_now_o    (start_now),
    .fade_out_o     (fade_out),
    .voice_freed_o  (voice_freed),
    .ramp_from_o    (ramp_from),
    .ramp_to_o      (ramp_to),
    .pitch_out_o    (pitch_out),
    .offset_out_o   (offset_out)
  );

  always #1 clk = ~clk;

  // End the run if it hangs
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Timeout after %0d cycles, %0d results still owed", cycle_count,
             sb.results_owed());
    $display("Regression FAIL");
    $finish;
  end

  // Check each accepted result item, then pick the next stall
  always @(posedge clk) begin
    if (out_valid && !out_stall)
      sb.compare_result({ok, handle_out, start_now, fade_out, voice_freed,
                         ramp_from, ramp_to, pitch_out, offset_out});
    out_stall <= ($urandom_range(99) < recv_stall_pct);
  end

  function automatic logic [WORD_W-1:0] pick_word();
    int q;
    q = $urandom_range(9);
    if (q == 0) return '0;
    if (q == 1) return '1;
    return $urandom;
  endfunction

  // Slot whose words were written at least once, or any slot at or beyond the usable count
  function automatic int pick_target_slot();
    int cand[$];
    for (int i = 0; i < MAX_VOICES; i++)
      if (sb.ever_played[i] || i >= sb.usable_slots()) cand.push_back(i);
    if (cand.size() == 0) return 0;
    return cand[$urandom_range(cand.size() - 1)];
  endfunction

  // Random payload; steer slot references away from never-written slots
  function automatic voice_cmd_t make_cmd(mode_e m);
    voice_cmd_t c;
    c.mode         = m;
    c.handle       = {$urandom, $urandom};
    c.voice_slot   = SLOT_W'($urandom);
    c.stream_ended = 1'($urandom_range(1));
    c.offset_word  = pick_word();
    c.volume_word  = pick_word();
    c.pitch_word   = pick_word();
    if (c.handle[63:32] < MAX_VOICES && !sb.ever_played[c.handle[38:32]])
      c.handle[63] = 1'b1;
    if (!sb.ever_played[c.voice_slot] && c.voice_slot < sb.usable_slots())
      c.voice_slot = SLOT_W'(pick_target_slot());
    return c;
  endfunction

  function automatic voice_cmd_t gen_cmd();
    voice_cmd_t c;
    int live[$];
    int r, q, s, b;
    for (int i = 0; i < MAX_VOICES; i++)
      if (sb.voice_on[i]) live.push_back(i);
    r = $urandom_range(99);
    if (!sb.playing && $urandom_range(3) == 0) r = 92;
    if (r < 22) begin
      c = make_cmd(MODE_PLAY);
    end else if (r < 50) begin
      c = make_cmd(mode_e'($urandom_range(int'(MODE_STOP_VOICE), int'(MODE_SET_PITCH))));
      q = $urandom_range(99);
      if (live.size() > 0 && q < 80) begin
        s = live[$urandom_range(live.size() - 1)];
        c.handle = sb.live_handle(s);
        // stale tag
        if (q >= 65) begin
          b = $urandom_range(TAG_W - 1);
          c.handle[b] = ~c.handle[b];
        end
      end else if (q >= 90) begin
        c.handle = {32'(pick_target_slot()), $urandom};
      end
    end else if (r < 90) begin
      c = make_cmd(MODE_MIX);
      if (live.size() > 0 && $urandom_range(3) != 0)
        c.voice_slot = SLOT_W'(live[$urandom_range(live.size() - 1)]);
      c.stream_ended = ($urandom_range(99) < 30);
    end else if (r < 94) begin
      c = make_cmd(MODE_START);
    end else if (r < 96) begin
      c = make_cmd(MODE_STOP_ALL);
    end else begin
      c = make_cmd(mode_e'($urandom_range(int'(MODE_STOP_ALL))));
    end
    return c;
  endfunction

  // Present one item and hold it until accepted
  task automatic send_item(input voice_cmd_t c);
    in_valid     <= 1'b1;
    mode         <= c.mode;
    handle       <= c.handle;
    voice_slot   <= c.voice_slot;
    stream_ended <= c.stream_ended;
    offset_word  <= c.offset_word;
    volume_word  <= c.volume_word;
    pitch_word   <= c.pitch_word;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.accept_cmd(c);
  endtask

  task automatic pace_sender();
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
  endtask

  // Hold off until every owed result is back and the pipe is empty
  task automatic drain();
    in_valid <= 1'b0;
    while (sb.results_owed() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_voice_count(input logic [COUNT_W-1:0] v);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    sb.set_count(v);
  endtask

  initial begin
    sb = new();
    count_plan = '{8'd32, 8'd1, 8'd0, 8'd128, 8'd255, 8'd3, 8'd0, 8'd8};
    count_plan[6] = COUNT_W'($urandom_range(255));

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: voice life cycle under the reset voice count
    dcmd = make_cmd(MODE_PLAY);
    dcmd.offset_word = '0; dcmd.volume_word = '0; dcmd.pitch_word = '0;
    send_item(dcmd);
    dcmd = make_cmd(MODE_PLAY);
    dcmd.offset_word = '1; dcmd.volume_word = '1; dcmd.pitch_word = '1;
    send_item(dcmd);
    // mix and stop all while the player is stopped
    dcmd = make_cmd(MODE_MIX);
    dcmd.voice_slot = '0;
    send_item(dcmd);
    send_item(make_cmd(MODE_STOP_ALL));
    send_item(make_cmd(MODE_START));
    dcmd = make_cmd(MODE_QUERY);
    dcmd.handle = sb.live_handle(0);
    send_item(dcmd);
    dcmd.handle = sb.live_handle(0) ^ 64'd1;
    send_item(dcmd);
    dcmd.handle = '1;
    send_item(dcmd);
    dcmd = make_cmd(MODE_SET_VOLUME);
    dcmd.handle = sb.live_handle(1);
    dcmd.volume_word = 32'h3f80_0000;
    send_item(dcmd);
    dcmd = make_cmd(MODE_SET_PITCH);
    dcmd.handle = sb.live_handle(1);
    dcmd.pitch_word = 32'h4000_0000;
    send_item(dcmd);
    // first mix starts the voice and ramps from the old volume
    dcmd = make_cmd(MODE_MIX);
    dcmd.voice_slot = 7'd1;
    dcmd.stream_ended = 1'b0;
    send_item(dcmd);
    send_item(dcmd);
    // stop before the voice ever played
    dcmd = make_cmd(MODE_STOP_VOICE);
    dcmd.handle = sb.live_handle(0);
    send_item(dcmd);
    dcmd = make_cmd(MODE_MIX);
    dcmd.voice_slot = '0;
    dcmd.stream_ended = 1'b0;
    send_item(dcmd);
    // stop a playing voice: fade out
    dcmd = make_cmd(MODE_STOP_VOICE);
    dcmd.handle = sb.live_handle(1);
    send_item(dcmd);
    dcmd = make_cmd(MODE_MIX);
    dcmd.voice_slot = 7'd1;
    dcmd.stream_ended = 1'b0;
    send_item(dcmd);
    // stream runs out on the first pass
    send_item(make_cmd(MODE_PLAY));
    dcmd = make_cmd(MODE_MIX);
    dcmd.voice_slot = '0;
    dcmd.stream_ended = 1'b1;
    send_item(dcmd);
    dcmd.voice_slot = '1;
    send_item(dcmd);
    // start while running clears the table
    send_item(make_cmd(MODE_PLAY));
    send_item(make_cmd(MODE_START));
    dcmd = make_cmd(MODE_QUERY);
    dcmd.handle = sb.live_handle(0);
    send_item(dcmd);
    send_item(make_cmd(MODE_STOP_ALL));

    // Random phases over voice counts and idling patterns
    for (int p = 0; p < N_PHASES; p++) begin
      drain();
      write_voice_count(count_plan[p]);
      case (p % 4)
        0:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1:       begin send_idle_pct = 68; recv_stall_pct = 0;  end
        2:       begin send_idle_pct = 0;  recv_stall_pct = 68; end
        default: begin send_idle_pct = 12; recv_stall_pct = 12; end
      endcase
      for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
        if (k == ITEMS_PER_PHASE / 2) drain();
        pace_sender();
        send_item(gen_cmd());
      end
    end

    drain();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    repeat (8) @(posedge clk);

    $display("Covered %0d items, %0d results checked, %0d voice-count settings",
             sb.n_items, sb.n_results, N_PHASES);
    $display("Plays %0d granted / %0d on full table, %0d valid handles, %0d mix hits, %0d freed",
             sb.n_alloc, sb.n_full, sb.n_handle_ok, sb.n_mix_hit, sb.n_freed);
    if (sb.errors == 0 && sb.results_owed() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("%0d mismatches, %0d results never returned", sb.errors, sb.results_owed());
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
